// File: hw/rtl/crse_pkg.sv
package crse_pkg;

   localparam int MAX_KNOTS   = 64;
   localparam int FRAC_BITS   = 16;
   localparam int KNOT_W      = 32;
   localparam int CNT_W       = 7;
   localparam int IDX_W       = 6;
   localparam int NUM_BANKS   = 4;
   localparam int BANK_SEL_W  = $clog2(NUM_BANKS);
   localparam int KNOT_AW     = $clog2(MAX_KNOTS);
   localparam int BANK_AW     = KNOT_AW - BANK_SEL_W;
   localparam int BANK_DEPTH  = MAX_KNOTS / NUM_BANKS;
   localparam int T_W         = FRAC_BITS + 1;
   localparam int SCALED_W    = T_W + CNT_W;
   localparam int SPAN_RAW_W  = SCALED_W - FRAC_BITS;
   localparam int ACC_W       = KNOT_W + 4;
   localparam int PROD_W      = ACC_W + T_W + 1;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EVAL = 1'b1;

   typedef logic signed [KNOT_W-1:0] knot_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic        [T_W-1:0]    frac_type;

endpackage

// File: hw/rtl/crse_ram.sv
module crse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (en && wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/catmull_rom_spline_eval_unit.sv
// an accepted request passes the stage registers s1_ff up to s6_ff and then the output register to rsp_valid
// throughput: one request per cycle while rsp_stall does not hold the pipeline, loads and evaluates mixed freely
// a held rsp_stall while rsp_valid is high freezes the whole pipeline, nothing is lost or repeated
// reset clears all pipeline valid bits and knot_count; the knot banks are not
// cleared and hold garbage until loaded
module catmull_rom_spline_eval_unit
   import crse_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CNT_W-1:0]        csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_kind,
   input  logic [IDX_W-1:0]        req_knot_index,
   input  logic signed [KNOT_W-1:0] req_knot_value,
   input  logic signed [KNOT_W-1:0] req_position,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [KNOT_W-1:0] rsp_spline_value,
   output logic                    rsp_too_few_knots,
   output logic                    rsp_saturated
);

   logic adv;

   // config
   logic [CNT_W-1:0] knot_count_ff, knot_count_in;
   logic [CNT_W-1:0] count_eff;
   logic             too_few;

   // stage 1
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_kind_ff;
   logic [IDX_W-1:0] s1_index_ff;
   knot_type         s1_value_ff;
   frac_type         s1_t_ff, s1_t_in;

   // stage 2
   logic                  s2_valid_ff, s2_valid_in;
   logic [BANK_SEL_W-1:0] s2_lo_ff, s2_lo_in;
   frac_type              s2_frac_ff, s2_frac_in;

   // stage 3
   logic     s3_valid_ff, s3_valid_in;
   acc_type  s3_c3_ff, s3_c2_ff, s3_c1_ff, s3_c0_ff;
   acc_type  s3_c3_in, s3_c2_in, s3_c1_in, s3_c0_in;
   frac_type s3_frac_ff;

   // stage 4..6
   logic                     s4_valid_ff, s4_valid_in;
   logic signed [PROD_W-1:0] s4_prod_ff, s4_prod_in;
   acc_type                  s4_c2_ff, s4_c1_ff, s4_c0_ff;
   frac_type                 s4_frac_ff;

   logic                     s5_valid_ff, s5_valid_in;
   logic signed [PROD_W-1:0] s5_prod_ff, s5_prod_in;
   acc_type                  s5_c1_ff, s5_c0_ff;
   frac_type                 s5_frac_ff;

   logic                     s6_valid_ff, s6_valid_in;
   logic signed [PROD_W-1:0] s6_prod_ff, s6_prod_in;
   acc_type                  s6_c0_ff;

   // output
   logic     rsp_valid_ff, rsp_valid_in;
   knot_type rsp_value_ff, rsp_value_in;
   logic     rsp_few_ff, rsp_few_in;
   logic     rsp_sat_ff, rsp_sat_in;

   // banks
   logic [BANK_AW-1:0] bank_rd_addr [NUM_BANKS];
   logic [NUM_BANKS-1:0] bank_we;
   logic [KNOT_W-1:0]  bank_rd_data [NUM_BANKS];
   logic               wr_in_range;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   assign knot_count_in = csr_wr_en ? csr_wr_data : knot_count_ff;
   assign count_eff = (knot_count_ff > CNT_W'(MAX_KNOTS)) ? CNT_W'(MAX_KNOTS) : knot_count_ff;
   assign too_few   = count_eff < CNT_W'(4);

   always_ff @(posedge clock) begin
      if (reset) begin
         knot_count_ff <= '0;
      end else begin
         knot_count_ff <= knot_count_in;
      end
   end

   // stage 0: accept and clamp position
   assign s1_valid_in = req_valid;
   always_comb begin
      if (req_position < 0) begin
         s1_t_in = '0;
      end else if (req_position > KNOT_W'(1 << FRAC_BITS)) begin
         s1_t_in = frac_type'(1 << FRAC_BITS);
      end else begin
         s1_t_in = req_position[T_W-1:0];
      end
   end

   // stage 1: span select, bank addressing, knot write
   logic [CNT_W-1:0]      spans, last_span, span;
   logic [SCALED_W-1:0]   scaled;
   logic [SPAN_RAW_W-1:0] span_raw;

   always_comb begin
      spans     = count_eff - CNT_W'(3);
      last_span = spans - CNT_W'(1);
      scaled    = SCALED_W'(s1_t_ff) * SCALED_W'(spans);
      span_raw  = scaled[SCALED_W-1:FRAC_BITS];
      if (span_raw > SPAN_RAW_W'(last_span)) begin
         span = last_span;
      end else begin
         span = CNT_W'(span_raw);
      end
      s2_frac_in  = T_W'(scaled - (SCALED_W'(span) << FRAC_BITS));
      s2_lo_in    = span[BANK_SEL_W-1:0];
      s2_valid_in = s1_valid_ff && (s1_kind_ff == KIND_EVAL);
   end

   assign wr_in_range = 32'(s1_index_ff) < MAX_KNOTS;

   genvar b;
   generate
      for (b = 0; b < NUM_BANKS; b++) begin : g_bank
         logic [BANK_SEL_W-1:0] off;
         logic [KNOT_AW-1:0]    idx;

         assign off = BANK_SEL_W'(b) - span[BANK_SEL_W-1:0];
         assign idx = KNOT_AW'(span) + KNOT_AW'(off);
         assign bank_rd_addr[b] = idx[KNOT_AW-1:BANK_SEL_W];
         assign bank_we[b] = s1_valid_ff && (s1_kind_ff == KIND_LOAD) && wr_in_range
                             && (s1_index_ff[BANK_SEL_W-1:0] == BANK_SEL_W'(b));

         crse_ram #(
            .WIDTH (KNOT_W),
            .DEPTH (BANK_DEPTH)
         ) u_bank (
            .clock   (clock),
            .en      (adv),
            .wr_en   (bank_we[b]),
            .wr_addr (s1_index_ff[KNOT_AW-1:BANK_SEL_W]),
            .wr_data (s1_value_ff),
            .rd_addr (bank_rd_addr[b]),
            .rd_data (bank_rd_data[b])
         );
      end
   endgenerate

   // stage 2: rotate banks into span order, basis coefficients
   acc_type k0, k1, k2, k3;
   acc_type sum3, sum2, sum1;

   always_comb begin
      k0 = ACC_W'($signed(bank_rd_data[s2_lo_ff]));
      k1 = ACC_W'($signed(bank_rd_data[BANK_SEL_W'(s2_lo_ff + BANK_SEL_W'(1))]));
      k2 = ACC_W'($signed(bank_rd_data[BANK_SEL_W'(s2_lo_ff + BANK_SEL_W'(2))]));
      k3 = ACC_W'($signed(bank_rd_data[BANK_SEL_W'(s2_lo_ff + BANK_SEL_W'(3))]));
      sum3 = k3 - k0 + (k1 - k2) * ACC_W'(3);
      sum2 = (k0 <<< 1) - k1 * ACC_W'(5) + (k2 <<< 2) - k3;
      sum1 = k2 - k0;
      s3_c3_in = sum3 >>> 1;
      s3_c2_in = sum2 >>> 1;
      s3_c1_in = sum1 >>> 1;
      s3_c0_in = k1;
      s3_valid_in = s2_valid_ff;
   end

   // stages 3..6: horner steps, one multiply in each of stages 3 to 5, stage 6 adds c0 and saturates
   acc_type acc1, acc2, acc3;

   always_comb begin
      s4_valid_in = s3_valid_ff;
      s4_prod_in  = PROD_W'(s3_c3_ff) * PROD_W'($signed({1'b0, s3_frac_ff}));

      acc1        = acc_type'(s4_prod_ff[FRAC_BITS +: ACC_W]) + s4_c2_ff;
      s5_valid_in = s4_valid_ff;
      s5_prod_in  = PROD_W'(acc1) * PROD_W'($signed({1'b0, s4_frac_ff}));

      acc2        = acc_type'(s5_prod_ff[FRAC_BITS +: ACC_W]) + s5_c1_ff;
      s6_valid_in = s5_valid_ff;
      s6_prod_in  = PROD_W'(acc2) * PROD_W'($signed({1'b0, s5_frac_ff}));

      acc3         = acc_type'(s6_prod_ff[FRAC_BITS +: ACC_W]) + s6_c0_ff;
      rsp_valid_in = s6_valid_ff;
      rsp_few_in   = too_few;
      if (too_few) begin
         rsp_value_in = '0;
         rsp_sat_in   = 1'b0;
      end else if (acc3 > ACC_W'(32'sh7fffffff)) begin
         rsp_value_in = 32'sh7fffffff;
         rsp_sat_in   = 1'b1;
      end else if (acc3 < -ACC_W'(64'sh80000000)) begin
         rsp_value_in = 32'sh80000000;
         rsp_sat_in   = 1'b1;
      end else begin
         rsp_value_in = acc3[KNOT_W-1:0];
         rsp_sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         s5_valid_ff  <= s5_valid_in;
         s6_valid_ff  <= s6_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff   <= req_kind;
         s1_index_ff  <= req_knot_index;
         s1_value_ff  <= req_knot_value;
         s1_t_ff      <= s1_t_in;
         s2_lo_ff     <= s2_lo_in;
         s2_frac_ff   <= s2_frac_in;
         s3_c3_ff     <= s3_c3_in;
         s3_c2_ff     <= s3_c2_in;
         s3_c1_ff     <= s3_c1_in;
         s3_c0_ff     <= s3_c0_in;
         s3_frac_ff   <= s2_frac_ff;
         s4_prod_ff   <= s4_prod_in;
         s4_c2_ff     <= s3_c2_ff;
         s4_c1_ff     <= s3_c1_ff;
         s4_c0_ff     <= s3_c0_ff;
         s4_frac_ff   <= s3_frac_ff;
         s5_prod_ff   <= s5_prod_in;
         s5_c1_ff     <= s4_c1_ff;
         s5_c0_ff     <= s4_c0_ff;
         s5_frac_ff   <= s4_frac_ff;
         s6_prod_ff   <= s6_prod_in;
         s6_c0_ff     <= s5_c0_ff;
         rsp_value_ff <= rsp_value_in;
         rsp_few_ff   <= rsp_few_in;
         rsp_sat_ff   <= rsp_sat_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_spline_value  = rsp_value_ff;
   assign rsp_too_few_knots = rsp_few_ff;
   assign rsp_saturated     = rsp_sat_ff;

   a_one_bank_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(bank_we))
      else $error("more than one knot bank written");

   a_eval_moves_on: assert property (@(posedge clock) disable iff (reset)
      adv && s1_valid_ff && (s1_kind_ff == KIND_EVAL) |=> s2_valid_ff)
      else $error("evaluate request dropped after span select");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      adv && s1_valid_ff && (s1_kind_ff == KIND_LOAD) |=> !s2_valid_ff)
      else $error("load request produced a result slot");

   a_few_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_few_knots |-> (rsp_spline_value == 0) && !rsp_saturated)
      else $error("too few knots with nonzero value");

   a_sat_is_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_spline_value == 32'sh7fffffff) || (rsp_spline_value == 32'sh80000000))
      else $error("saturated value not at a rail");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench
   import crse_pkg::*;
();

   localparam int LATENCY = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int IDLE_PERCENT = 21;
   localparam knot_type KNOT_MAX = 32'sh7FFF_FFFF;
   localparam knot_type KNOT_MIN = 32'sh8000_0000;
   localparam knot_type POS_ONE = 32'sh0001_0000;
   localparam knot_type POS_HALF = 32'sh0000_8000;

   typedef struct packed {
      knot_type value;
      logic     too_few;
      logic     clipped;
   } spline_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_wr_en = 1'b0;
   logic [CNT_W-1:0]        csr_wr_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_kind = KIND_LOAD;
   logic [IDX_W-1:0]        req_knot_index = '0;
   knot_type                req_knot_value = '0;
   knot_type                req_position = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   knot_type                rsp_spline_value;
   logic                    rsp_too_few_knots;
   logic                    rsp_saturated;

   longint                  knot_mirror [MAX_KNOTS];
   int unsigned             knot_count_mirror = 0;
   spline_result_type       expected_spline_q [$];
   int                      mismatch_count = 0;
   int                      quiet_cycles = 0;
   bit                      no_idle = 1'b0;

   catmull_rom_spline_eval_unit uut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_knot_index    (req_knot_index),
      .req_knot_value    (req_knot_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_spline_value  (rsp_spline_value),
      .rsp_too_few_knots (rsp_too_few_knots),
      .rsp_saturated     (rsp_saturated)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic spline_result_type predict_spline(input knot_type position);
      spline_result_type r;
      longint one, cnt, spans, t, scaled, span, frac;
      longint k0, k1, k2, k3, c0, c1, c2, c3, acc;
      one = longint'(1) <<< FRAC_BITS;
      cnt = knot_count_mirror;
      if (cnt > MAX_KNOTS) cnt = MAX_KNOTS;
      r.value = '0;
      r.clipped = 1'b0;
      r.too_few = 1'b0;
      if (cnt < 4) begin
         r.too_few = 1'b1;
         return r;
      end
      spans = cnt - 3;
      t = position;
      if (t < 0) t = 0;
      if (t > one) t = one;
      scaled = t * spans;
      span = scaled >>> FRAC_BITS;
      if (span > spans - 1) span = spans - 1;
      frac = scaled - span * one;
      k0 = knot_mirror[span];
      k1 = knot_mirror[span + 1];
      k2 = knot_mirror[span + 2];
      k3 = knot_mirror[span + 3];
      c3 = (-k0 + 3 * k1 - 3 * k2 + k3) >>> 1;
      c2 = (2 * k0 - 5 * k1 + 4 * k2 - k3) >>> 1;
      c1 = (k2 - k0) >>> 1;
      c0 = k1;
      acc = ((c3 * frac) >>> FRAC_BITS) + c2;
      acc = ((acc * frac) >>> FRAC_BITS) + c1;
      acc = ((acc * frac) >>> FRAC_BITS) + c0;
      if (acc > longint'(KNOT_MAX)) begin
         acc = KNOT_MAX;
         r.clipped = 1'b1;
      end
      if (acc < longint'(KNOT_MIN)) begin
         acc = KNOT_MIN;
         r.clipped = 1'b1;
      end
      r.value = knot_type'(acc);
      return r;
   endfunction

   function automatic knot_type rand_knot();
      case ($urandom_range(3))
         0: return knot_type'($urandom);
         1: return $urandom_range(1) ? KNOT_MAX : KNOT_MIN;
         default: return knot_type'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      endcase
   endfunction

   function automatic knot_type rand_position();
      case ($urandom_range(9))
         6: return knot_type'($urandom);
         7: return $urandom_range(1) ? POS_ONE : knot_type'($urandom_range(0, 3));
         8: return knot_type'($urandom_range(32'h0001_0001, 32'h7FFF_FFFF));
         9: return -knot_type'($urandom_range(1, 32'h7FFF_FFFF));
         default: return knot_type'($urandom_range(0, 32'h0001_0000));
      endcase
   endfunction

   task automatic flag_mismatch(input string detail);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", detail);
   endtask

   task automatic send_request(input logic kind, input logic [IDX_W-1:0] index,
                               input knot_type value, input knot_type position);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_knot_index <= index;
      req_knot_value <= value;
      req_position <= position;
      do @(posedge clock); while (req_stall);
      if (kind == KIND_LOAD) knot_mirror[index] = value;
      else expected_spline_q.push_back(predict_spline(position));
   endtask

   task automatic load_knot(input logic [IDX_W-1:0] index, input knot_type value);
      send_request(KIND_LOAD, index, value, knot_type'($urandom));
   endtask

   task automatic evaluate_at(input knot_type position);
      send_request(KIND_EVAL, IDX_W'($urandom), knot_type'($urandom), position);
   endtask

   // loads leave no result behind, so also let the pipeline run empty
   task automatic wait_drained();
      int moving;
      req_valid <= 1'b0;
      while (expected_spline_q.size() != 0) @(posedge clock);
      moving = 0;
      while (moving < LATENCY + 2) begin
         @(posedge clock);
         if (!rsp_stall) moving++;
      end
   endtask

   task automatic write_knot_count(input logic [CNT_W-1:0] count);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      knot_count_mirror = count;
   endtask

   task automatic test_too_few_knots();
      write_knot_count(0);
      evaluate_at(0);
      evaluate_at(POS_ONE);
      evaluate_at(rand_position());
      write_knot_count(3);
      evaluate_at(KNOT_MIN);
      evaluate_at(KNOT_MAX);
   endtask

   task automatic test_saturation_and_positions();
      write_knot_count(4);
      load_knot(0, KNOT_MIN);
      load_knot(1, KNOT_MAX);
      load_knot(2, KNOT_MAX);
      load_knot(3, KNOT_MIN);
      evaluate_at(POS_HALF);
      evaluate_at(0);
      evaluate_at(POS_ONE);
      load_knot(0, KNOT_MAX);
      load_knot(1, KNOT_MIN);
      load_knot(2, KNOT_MIN);
      load_knot(3, KNOT_MAX);
      evaluate_at(POS_HALF);
      evaluate_at(KNOT_MIN);
      evaluate_at(-1);
      evaluate_at(1);
      evaluate_at(POS_ONE - 1);
      evaluate_at(POS_ONE + 1);
      evaluate_at(KNOT_MAX);
      load_knot(IDX_W'(MAX_KNOTS - 1), rand_knot());
   endtask

   task automatic test_full_table_counts();
      logic [CNT_W-1:0] counts [5] = '{7'd64, 7'd65, 7'd127, 7'd5, 7'd63};
      for (int i = 0; i < MAX_KNOTS; i++) load_knot(IDX_W'(i), rand_knot());
      foreach (counts[i]) begin
         write_knot_count(counts[i]);
         evaluate_at(0);
         evaluate_at(POS_ONE);
         evaluate_at(KNOT_MAX);
         evaluate_at(rand_position());
      end
   endtask

   task automatic test_random_mix();
      logic [CNT_W-1:0] edge_counts [6] = '{7'd0, 7'd3, 7'd4, 7'd64, 7'd65, 7'd127};
      for (int phase = 0; phase < 9; phase++) begin
         if (phase == 0) write_knot_count(4);
         else if ($urandom_range(1)) write_knot_count(CNT_W'($urandom_range(0, 127)));
         else write_knot_count(edge_counts[$urandom_range(5)]);
         repeat (110) begin
            if ($urandom_range(3) == 0) load_knot(IDX_W'($urandom), rand_knot());
            else evaluate_at(rand_position());
         end
      end
   endtask

   task automatic test_back_to_back();
      write_knot_count(CNT_W'($urandom_range(4, 64)));
      no_idle = 1'b1;
      repeat (250) begin
         if ($urandom_range(4) == 0) load_knot(IDX_W'($urandom), rand_knot());
         else evaluate_at(rand_position());
      end
      wait_drained();
      no_idle = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin : check_results
      spline_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_spline_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected result: value %0d too_few %b saturated %b",
                                    rsp_spline_value, rsp_too_few_knots, rsp_saturated));
         end else begin
            want = expected_spline_q.pop_front();
            if (rsp_spline_value !== want.value)
               flag_mismatch($sformatf("spline_value: expected %0d actual %0d",
                                       want.value, rsp_spline_value));
            if (rsp_too_few_knots !== want.too_few)
               flag_mismatch($sformatf("too_few_knots: expected %b actual %b",
                                       want.too_few, rsp_too_few_knots));
            if (rsp_saturated !== want.clipped)
               flag_mismatch($sformatf("saturated: expected %b actual %b",
                                       want.clipped, rsp_saturated));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_too_few_knots();
      test_saturation_and_positions();
      test_full_table_counts();
      test_random_mix();
      test_back_to_back();
      wait_drained();
      repeat (2 * LATENCY) @(posedge clock);
      if (expected_spline_q.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", expected_spline_q.size()));
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
